// ----- rtl/fsr_pkg.sv -----
// Package: widths, payload structs, divider request/response and sequencer states.
`default_nettype none
package fsr_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CntWidth  = $clog2(DataWidth);

  typedef struct packed {
    logic signed [DataWidth-1:0] numerator;
    logic signed [DataWidth-1:0] denominator;
  } fsr_in_t;

  typedef struct packed {
    logic                 negative;
    logic [DataWidth-1:0] reduced_numerator;
    logic [DataWidth-1:0] reduced_denominator;
    logic                 zero_denominator;
  } fsr_out_t;

  typedef struct packed {
    logic                 start;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } fsr_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] quotient;
    logic [DataWidth-1:0] remainder;
  } fsr_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_GCD_WAIT,
    ST_QN,
    ST_QN_WAIT,
    ST_QD,
    ST_QD_WAIT,
    ST_FINISH
  } fsr_state_e;

endpackage
`default_nettype wire

// ----- rtl/fraction_sign_and_reduce.sv -----
// Top level: sign, zero checks and Euclid/quotient sequencer around the shared divider.
//
//   channel | signals                              | direction
//   in      | in_valid_i, in_ready_o, in_data_i    | request in (numerator, denominator)
//   out     | out_valid_o, out_ready_i, out_data_o | reduced fraction out
//
// One request at a time. Zero denominator or zero numerator: straight to the
// finish state with no division. Otherwise the shared divider runs once per
// Euclid step, then once for each of the two reduced quotients.
// Reset clears the sequencer and the output valid. A new request is taken while
// a result waits in the output register; a stalled output holds the next result.
`default_nettype none
module fraction_sign_and_reduce import fsr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire fsr_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output fsr_out_t     out_data_o
);

  fsr_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  fsr_out_t             out_q, out_d;
  logic [DataWidth-1:0] mn_q, mn_d, md_q, md_d;
  logic [DataWidth-1:0] a_q, a_d, b_q, b_d;
  logic [DataWidth-1:0] rn_q, rn_d, rd_q, rd_d;
  logic                 neg_q, neg_d, zd_q, zd_d;

  logic [DataWidth-1:0] n_u, d_u, n_mag, d_mag;
  logic                 n_neg, d_neg, n_pos, d_pos;

  fsr_div_req_t div_req;
  fsr_div_rsp_t div_rsp;

  fsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    n_u   = in_data_i.numerator;
    d_u   = in_data_i.denominator;
    n_neg = n_u[DataWidth-1];
    d_neg = d_u[DataWidth-1];
    n_pos = (n_u != '0) && !n_neg;
    d_pos = (d_u != '0) && !d_neg;
    n_mag = n_neg ? (~n_u + DataWidth'(1)) : n_u;
    d_mag = d_neg ? (~d_u + DataWidth'(1)) : d_u;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mn_d        = mn_q;
    md_d        = md_q;
    a_d         = a_q;
    b_d         = b_q;
    rn_d        = rn_q;
    rd_d        = rd_q;
    neg_d       = neg_q;
    zd_d        = zd_q;
    div_req     = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mn_d  = n_mag;
          md_d  = d_mag;
          a_d   = n_mag;
          b_d   = d_mag;
          neg_d = (n_neg && d_pos) || (n_pos && d_neg);
          zd_d  = 1'b0;
          rn_d  = '0;
          rd_d  = '0;
          if (d_mag == '0) begin
            zd_d    = 1'b1;
            neg_d   = 1'b0;
            state_d = ST_FINISH;
          end else if (n_mag == '0) begin
            rd_d    = DataWidth'(1);
            state_d = ST_FINISH;
          end else begin
            state_d = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        div_req.start    = 1'b1;
        div_req.dividend = a_q;
        div_req.divisor  = b_q;
        state_d          = ST_GCD_WAIT;
      end
      ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          a_d = b_q;
          b_d = div_rsp.remainder;
          state_d = (div_rsp.remainder == '0) ? ST_QN : ST_GCD;
        end
      end
      ST_QN: begin
        div_req.start    = 1'b1;
        div_req.dividend = mn_q;
        div_req.divisor  = a_q;
        state_d          = ST_QN_WAIT;
      end
      ST_QN_WAIT: begin
        if (div_rsp.done) begin
          rn_d    = div_rsp.quotient;
          state_d = ST_QD;
        end
      end
      ST_QD: begin
        div_req.start    = 1'b1;
        div_req.dividend = md_q;
        div_req.divisor  = a_q;
        state_d          = ST_QD_WAIT;
      end
      ST_QD_WAIT: begin
        if (div_rsp.done) begin
          rd_d    = div_rsp.quotient;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.negative            = neg_q;
          out_d.reduced_numerator   = rn_q;
          out_d.reduced_denominator = rd_q;
          out_d.zero_denominator    = zd_q;
          out_valid_d               = 1'b1;
          state_d                   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    mn_q  <= mn_d;
    md_q  <= md_d;
    a_q   <= a_d;
    b_q   <= b_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    neg_q <= neg_d;
    zd_q  <= zd_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- rtl/fsr_div.sv -----
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none
module fsr_div import fsr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire fsr_div_req_t req_i,
  output fsr_div_rsp_t      rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [DataWidth-1:0] dsr_q, dsr_d;

  logic [DataWidth:0]   shifted;
  logic [DataWidth:0]   diff;
  logic                 ge;

  always_comb begin
    shifted = {rem_q, quo_q[DataWidth-1]};
    diff    = shifted - {1'b0, dsr_q};
    // shifted < 2 * divisor, so the top bit of diff is the borrow
    ge      = !diff[DataWidth];
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(DataWidth - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
      quo_d = {quo_q[DataWidth-2:0], ge};
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire
